FILE: hw/rtl/igpd_pkg.sv
// ---------------------------------------------------------------------------
// igpd_pkg
// Shared types, codes and the record layout table of the packet deframer.
// ---------------------------------------------------------------------------
package igpd_pkg;

	// framing bytes
	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_SENSOR = 8'h53;
	localparam logic [7:0] TYPE_FULL   = 8'h4E;
	localparam logic [7:0] GPS_MARK    = 8'h47;

	// frame geometry
	localparam int unsigned FRAME_DEPTH = 86;
	localparam logic [6:0] LEN_SENSOR        = 7'd51;
	localparam logic [6:0] LEN_FULL          = 7'd86;
	localparam logic [6:0] SERVO_BASE_SENSOR = 7'd32;
	localparam logic [6:0] SERVO_BASE_FULL   = 7'd67;
	localparam logic [6:0] CH4_HI_SENSOR     = 7'd41;
	localparam logic [6:0] CH4_HI_FULL       = 7'd76;
	localparam logic [6:0] GPS_MARK_ADDR     = 7'd33;
	localparam logic [6:0] FIRST_BODY_INDEX  = 7'd3;

	// record ids
	localparam logic [4:0] ID_FIRST      = 5'd0;
	localparam logic [4:0] ID_LAST_SERVO = 5'd19;
	localparam logic [4:0] ID_SUMMARY    = 5'd27;

	// frame kind codes
	localparam logic [1:0] KIND_SENSOR  = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	// frame status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
	localparam logic [1:0] STATUS_NO_GPS   = 2'd2;
	localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

	// configuration register indexes and reset values
	localparam logic [1:0] REG_AUTO_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MANUAL_CEILING = 2'd1;
	localparam logic [1:0] REG_HOLDOFF_RELOAD = 2'd2;
	localparam logic [15:0] AUTO_THRESHOLD_RST = 16'd12000;
	localparam logic [15:0] MANUAL_CEILING_RST = 16'd60000;
	localparam logic [6:0]  HOLDOFF_RELOAD_RST = 7'd15;

	// byte assembly formats
	localparam logic [1:0] FMT_BE_S = 2'd0;  // big-endian 16, sign-extended
	localparam logic [1:0] FMT_BE_U = 2'd1;  // big-endian, zero-extended
	localparam logic [1:0] FMT_LE   = 2'd2;  // little-endian, zero-extended

	typedef struct packed {
		logic [15:0] auto_threshold;
		logic [15:0] manual_ceiling;
		logic [6:0]  holdoff_reload;
	} mode_cfg_t;

	typedef struct packed {
		logic autopilot_on;
		logic entered_autopilot;
	} mode_stat_t;

	typedef struct packed {
		logic [6:0] addr;
		logic [2:0] nbytes;
		logic [1:0] fmt;
	} rec_info_t;

	// Where each record's bytes live in the frame store and how they combine.
	function automatic rec_info_t rec_info(input logic [4:0] rec, input logic is_full);
		rec_info_t  info;
		logic [6:0] base;
		logic [6:0] r7;
		logic [6:0] off;
		base = is_full ? SERVO_BASE_FULL : SERVO_BASE_SENSOR;
		r7 = {2'b00, rec};
		off = 7'd0;
		info.addr = 7'd0;
		info.nbytes = 3'd0;
		info.fmt = FMT_BE_U;
		priority if (rec <= 5'd8) begin
			info.addr = 7'd3 + {r7[5:0], 1'b0};
			info.nbytes = 3'd2;
			info.fmt = FMT_BE_S;
		end else if (rec == 5'd9) begin
			info.addr = 7'd27;
			info.nbytes = 3'd2;
			info.fmt = FMT_BE_S;
		end else if (rec == 5'd10) begin
			info.addr = 7'd29;
			info.nbytes = 3'd2;
			info.fmt = FMT_BE_S;
		end else if (rec == 5'd11) begin
			info.addr = base;
			info.nbytes = 3'd1;
			info.fmt = FMT_BE_U;
		end else if (rec <= 5'd19) begin
			off = r7 - 7'd12;
			info.addr = base + 7'd1 + {off[5:0], 1'b0};
			info.nbytes = 3'd2;
			info.fmt = FMT_BE_U;
		end else if (rec <= 5'd25) begin
			off = r7 - 7'd20;
			info.addr = 7'd34 + {off[4:0], 2'b00};
			info.nbytes = 3'd4;
			info.fmt = FMT_LE;
		end else if (rec == 5'd26) begin
			info.addr = 7'd58;
			info.nbytes = 3'd2;
			info.fmt = FMT_LE;
		end else begin
			info.addr = 7'd0;
			info.nbytes = 3'd0;
			info.fmt = FMT_BE_U;
		end
		return info;
	endfunction

endpackage

FILE: hw/rtl/imu_gps_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// imu_gps_packet_deframer_core
// Serial byte deframer for sensor / GPS packets with checksum, record output
// and autopilot mode tracking.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while a frame is being collected.
// Sequence: after the last byte the mode is updated, then for each record every
//   stored byte is read from the frame store and folded into the record, and
//   the record is loaded into the output register; an 'N' frame with GPS emits
//   28 records. in_ready stays low until the summary record is loaded.
// Reset: arst_n clears control, mode and configuration; the frame store needs
//   no clearing pass since only bytes of the current frame are ever read.
// ---------------------------------------------------------------------------
module imu_gps_packet_deframer_core (
	input  logic               clk,
	input  logic               arst_n,
	// byte input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// record output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         field_id,
	output logic signed [31:0] field_value,
	output logic [1:0]         frame_kind,
	output logic [1:0]         frame_status,
	output logic               autopilot_on,
	output logic               entered_autopilot,
	output logic               last,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;  // collect bytes
	localparam logic [2:0] ST_MODE = 3'd1;  // update the mode after a frame
	localparam logic [2:0] ST_READ = 3'd2;  // address the frame store
	localparam logic [2:0] ST_CAPT = 3'd3;  // fold the read byte into the record
	localparam logic [2:0] ST_PUSH = 3'd4;  // hand the record to the output register

	logic [2:0] state_q;

	// configuration registers
	igpd_pkg::mode_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_threshold <= igpd_pkg::AUTO_THRESHOLD_RST;
			cfg_q.manual_ceiling <= igpd_pkg::MANUAL_CEILING_RST;
			cfg_q.holdoff_reload <= igpd_pkg::HOLDOFF_RELOAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				igpd_pkg::REG_AUTO_THRESHOLD: cfg_q.auto_threshold <= cfg_data;
				igpd_pkg::REG_MANUAL_CEILING: cfg_q.manual_ceiling <= cfg_data;
				igpd_pkg::REG_HOLDOFF_RELOAD: cfg_q.holdoff_reload <= cfg_data[6:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// frame collection state
	logic [6:0]  byte_idx_q;   // zero while hunting for a header
	logic [1:0]  hdr_cnt_q;
	logic [15:0] sum_q;
	logic        full_q;       // frame type 'N'
	logic [7:0]  prev_q;       // previous byte, trailer high byte at frame end
	logic [15:0] ch4_q;        // servo channel four as seen in the stream
	logic        gps_ok_q;     // GPS marker present at its byte
	logic [15:0] mode_ch_q;    // last good servo channel four

	// per-frame outcome and emission state
	logic [1:0]  kind_q;
	logic [1:0]  status_q;
	logic [4:0]  rec_q;
	logic [1:0]  cnt_q;
	logic [31:0] acc_q;
	logic [31:0] val_q;

	// frame store
	logic [7:0] frame_mem [0:igpd_pkg::FRAME_DEPTH-1];
	logic [7:0] rd_data_q;

	logic       in_xfer;
	logic       out_free;
	logic       mem_we;
	logic [6:0] rd_addr;
	logic [6:0] frame_len;
	logic [6:0] sum_last;
	logic [6:0] ch4_hi_addr;
	logic       trailer_ok;
	logic       mode_upd;
	logic       rec_last_byte;
	logic       gps_emit;
	logic [4:0] next_rec;
	logic [31:0] asm_base;
	logic [31:0] asm_val;
	logic [31:0] fmt_val;

	igpd_pkg::rec_info_t  info;
	igpd_pkg::mode_stat_t mode_stat;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	assign frame_len = full_q ? igpd_pkg::LEN_FULL : igpd_pkg::LEN_SENSOR;
	assign sum_last = frame_len - 7'd3;
	assign ch4_hi_addr = full_q ? igpd_pkg::CH4_HI_FULL : igpd_pkg::CH4_HI_SENSOR;
	// running sum stops two bytes before the end, so it is final here
	assign trailer_ok = (sum_q == {prev_q, rx_byte});
	assign mem_we = in_xfer && (byte_idx_q != 7'd0);
	assign mode_upd = (state_q == ST_MODE);

	// record table lookup for the record being built
	assign info = igpd_pkg::rec_info(rec_q, kind_q == igpd_pkg::KIND_FULL);
	assign rd_addr = info.addr + {5'd0, cnt_q};
	assign rec_last_byte = ({1'b0, cnt_q} == (info.nbytes - 3'd1));
	assign gps_emit = (kind_q == igpd_pkg::KIND_FULL) && (status_q == igpd_pkg::STATUS_OK);
	assign next_rec = ((rec_q == igpd_pkg::ID_LAST_SERVO) && !gps_emit) ?
		igpd_pkg::ID_SUMMARY : rec_q + 5'd1;

	// byte assembly: big-endian shifts in, little-endian places by position
	always_comb begin
		asm_base = (cnt_q == 2'd0) ? 32'd0 : acc_q;
		asm_val = asm_base;
		if (info.fmt == igpd_pkg::FMT_LE) begin
			unique case (cnt_q)
				2'd0: asm_val[7:0] = rd_data_q;
				2'd1: asm_val[15:8] = rd_data_q;
				2'd2: asm_val[23:16] = rd_data_q;
				2'd3: asm_val[31:24] = rd_data_q;
				default: asm_val = asm_base;
			endcase
		end else begin
			asm_val = {asm_base[23:0], rd_data_q};
		end
		if (info.fmt == igpd_pkg::FMT_BE_S) begin
			fmt_val = {{16{asm_val[15]}}, asm_val[15:0]};
		end else begin
			fmt_val = asm_val;
		end
	end

	// frame store: one write port from the byte stream, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[byte_idx_q] <= rx_byte;
		end
		rd_data_q <= frame_mem[rd_addr];
	end

	igpd_mode u_mode (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (mode_upd),
		.mode_channel (mode_ch_q),
		.cfg          (cfg_q),
		.stat         (mode_stat)
	);

	// collection and emission sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			byte_idx_q <= 7'd0;
			hdr_cnt_q <= 2'd0;
			sum_q <= 16'd0;
			full_q <= 1'b0;
			mode_ch_q <= 16'd0;
			kind_q <= igpd_pkg::KIND_SENSOR;
			status_q <= igpd_pkg::STATUS_OK;
			rec_q <= igpd_pkg::ID_FIRST;
			cnt_q <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (byte_idx_q == 7'd0) begin
							if (hdr_cnt_q < 2'd2) begin
								// hunt for the two sync bytes
								hdr_cnt_q <= (rx_byte == igpd_pkg::SYNC_BYTE) ?
									hdr_cnt_q + 2'd1 : 2'd0;
							end else begin
								hdr_cnt_q <= 2'd0;
								if (rx_byte == igpd_pkg::TYPE_SENSOR ||
									rx_byte == igpd_pkg::TYPE_FULL) begin
									full_q <= (rx_byte == igpd_pkg::TYPE_FULL);
									sum_q <= {8'd0, rx_byte};
									byte_idx_q <= igpd_pkg::FIRST_BODY_INDEX;
								end else begin
									// unknown type: summary only
									kind_q <= igpd_pkg::KIND_UNKNOWN;
									status_q <= igpd_pkg::STATUS_UNKNOWN;
									state_q <= ST_MODE;
								end
							end
						end else begin
							if (byte_idx_q <= sum_last) begin
								sum_q <= sum_q + {8'd0, rx_byte};
							end
							if (byte_idx_q == frame_len - 7'd1) begin
								// frame complete: check trailer, latch the outcome
								byte_idx_q <= 7'd0;
								kind_q <= full_q ? igpd_pkg::KIND_FULL :
									igpd_pkg::KIND_SENSOR;
								state_q <= ST_MODE;
								if (!trailer_ok) begin
									status_q <= igpd_pkg::STATUS_CHECKSUM;
								end else begin
									mode_ch_q <= ch4_q;
									status_q <= (full_q && !gps_ok_q) ?
										igpd_pkg::STATUS_NO_GPS : igpd_pkg::STATUS_OK;
								end
							end else begin
								byte_idx_q <= byte_idx_q + 7'd1;
							end
						end
					end
				end
				ST_MODE: begin
					cnt_q <= 2'd0;
					if (status_q == igpd_pkg::STATUS_CHECKSUM ||
						status_q == igpd_pkg::STATUS_UNKNOWN) begin
						rec_q <= igpd_pkg::ID_SUMMARY;
						state_q <= ST_PUSH;
					end else begin
						rec_q <= igpd_pkg::ID_FIRST;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CAPT;
				end
				ST_CAPT: begin
					if (rec_last_byte) begin
						state_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q + 2'd1;
						state_q <= ST_READ;
					end
				end
				ST_PUSH: begin
					// hold until the output register can take the record
					if (out_free) begin
						cnt_q <= 2'd0;
						if (rec_q == igpd_pkg::ID_SUMMARY) begin
							state_q <= ST_IDLE;
						end else begin
							rec_q <= next_rec;
							state_q <= (next_rec == igpd_pkg::ID_SUMMARY) ? ST_PUSH : ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stream captures and record assembly: payload only, no reset
	always_ff @(posedge clk) begin
		if (mem_we) begin
			prev_q <= rx_byte;
			if (byte_idx_q == ch4_hi_addr) begin
				ch4_q[15:8] <= rx_byte;
			end
			if (byte_idx_q == ch4_hi_addr + 7'd1) begin
				ch4_q[7:0] <= rx_byte;
			end
			if (byte_idx_q == igpd_pkg::GPS_MARK_ADDR) begin
				gps_ok_q <= (rx_byte == igpd_pkg::GPS_MARK);
			end
		end
		if (state_q == ST_CAPT) begin
			acc_q <= asm_val;
			if (rec_last_byte) begin
				val_q <= fmt_val;
			end
		end
	end

	// output register: one record per transfer
	logic out_valid_q;
	logic [4:0] field_id_q;
	logic [31:0] field_value_q;
	logic [1:0] frame_kind_q;
	logic [1:0] frame_status_q;
	logic autopilot_on_q;
	logic entered_q;
	logic last_q;
	logic out_load;

	assign out_load = (state_q == ST_PUSH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			field_id_q <= rec_q;
			field_value_q <= (rec_q == igpd_pkg::ID_SUMMARY) ? 32'd0 : val_q;
			frame_kind_q <= kind_q;
			frame_status_q <= status_q;
			autopilot_on_q <= mode_stat.autopilot_on;
			entered_q <= mode_stat.entered_autopilot;
			last_q <= (rec_q == igpd_pkg::ID_SUMMARY);
		end
	end

	assign out_valid = out_valid_q;
	assign field_id = field_id_q;
	assign field_value = field_value_q;
	assign frame_kind = frame_kind_q;
	assign frame_status = frame_status_q;
	assign autopilot_on = autopilot_on_q;
	assign entered_autopilot = entered_q;
	assign last = last_q;

endmodule

FILE: hw/rtl/igpd_mode.sv
// ---------------------------------------------------------------------------
// igpd_mode
// Autopilot / manual mode tracker with a delayed fall-back to manual.
// ---------------------------------------------------------------------------
module igpd_mode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  logic [15:0]           mode_channel,
	input  igpd_pkg::mode_cfg_t   cfg,
	output igpd_pkg::mode_stat_t  stat
);

	logic       autopilot_q;
	logic       entered_q;
	logic [7:0] holdoff_q;  // two's complement, floor at -1

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			autopilot_q <= 1'b0;
			entered_q <= 1'b0;
			holdoff_q <= 8'd0;
		end else if (upd) begin
			priority if (mode_channel <= cfg.auto_threshold) begin
				entered_q <= !autopilot_q;
				autopilot_q <= 1'b1;
				holdoff_q <= {1'b0, cfg.holdoff_reload};
			end else if (mode_channel < cfg.manual_ceiling) begin
				entered_q <= 1'b0;
				if (holdoff_q[7]) begin
					autopilot_q <= 1'b0;
				end else begin
					holdoff_q <= holdoff_q - 8'd1;
				end
			end else begin
				entered_q <= 1'b0;
			end
		end
	end

	assign stat.autopilot_on = autopilot_q;
	assign stat.entered_autopilot = entered_q;

endmodule

FILE: tb/sv/tb_imu_gps_packet_deframer_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_imu_gps_packet_deframer_core
// Self-checking bench for the packet deframer: feeds sync-framed sensor and
// GPS packets, hunting noise and broken headers over the byte channel,
// predicts every decoded record and mode bit, and compares the record stream
// in order while both channels stall at random.
// ---------------------------------------------------------------------------
module tb_imu_gps_packet_deframer_core;

	// record ids that the package does not name
	localparam logic [4:0] ID_PS            = 5'd9;
	localparam logic [4:0] ID_PT            = 5'd10;
	localparam logic [4:0] ID_SERVO_STATUS  = 5'd11;
	localparam logic [4:0] ID_CH0           = 5'd12;
	localparam logic [4:0] ID_GPS0          = 5'd20;
	localparam logic [4:0] ID_GPS_TOW       = 5'd26;

	// byte offsets inside a frame
	localparam int SENSOR_WORDS = 9;
	localparam int PS_AT        = 27;
	localparam int PT_AT        = 29;
	localparam int GPS_AT       = 34;
	localparam int GPS_WORDS    = 6;
	localparam int TOW_AT       = 58;
	localparam int SERVO_CHANS  = 8;
	localparam int CH4_OFFSET   = 9;

	// body fill patterns for directed frames
	localparam int FILL_RANDOM  = 0;
	localparam int FILL_EXTREME = 1;
	localparam int FILL_ONES    = 2;
	localparam int FILL_ZEROS   = 3;

	localparam int RANDOM_SEQS_PER_PHASE = 26;
	localparam int CFG_SLACK_CYCLES      = 16;
	localparam int END_SLACK_CYCLES      = 200;
	localparam int WATCHDOG_CYCLES       = 1_000_000;

	typedef struct packed {
		logic [4:0]  id;
		logic [31:0] value;
		logic [1:0]  kind;
		logic [1:0]  status;
		logic        autopilot;
		logic        entered;
		logic        last;
	} deframe_rec_t;

	// -----------------------------------------------------------------------
	// Scoreboard: own copy of the deframer state, the decoded records it
	// predicts, and the in-order comparison against the DUT record stream.
	// -----------------------------------------------------------------------
	class deframer_scoreboard;
		logic [7:0]   frame_buf [0:igpd_pkg::FRAME_DEPTH-1];
		logic [6:0]   byte_pos;
		logic [1:0]   sync_run;
		logic [15:0]  csum;
		logic         full_frame;
		logic [15:0]  mode_chan;
		logic         autopilot;
		logic [7:0]   holdoff;
		logic [15:0]  auto_thr;
		logic [15:0]  manual_ceil;
		logic [6:0]   hold_reload;
		deframe_rec_t expected_records [$];
		int errors, checked;
		int n_good, n_bad_sum, n_no_gps, n_unknown, n_entries, n_fallbacks;

		function new();
			byte_pos = '0;
			sync_run = '0;
			csum = '0;
			full_frame = 1'b0;
			mode_chan = '0;
			autopilot = 1'b0;
			holdoff = '0;
			auto_thr = igpd_pkg::AUTO_THRESHOLD_RST;
			manual_ceil = igpd_pkg::MANUAL_CEILING_RST;
			hold_reload = igpd_pkg::HOLDOFF_RELOAD_RST;
			errors = 0;
			checked = 0;
			n_good = 0;
			n_bad_sum = 0;
			n_no_gps = 0;
			n_unknown = 0;
			n_entries = 0;
			n_fallbacks = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [15:0] value);
			case (idx)
				igpd_pkg::REG_AUTO_THRESHOLD: auto_thr = value;
				igpd_pkg::REG_MANUAL_CEILING: manual_ceil = value;
				igpd_pkg::REG_HOLDOFF_RELOAD: hold_reload = value[6:0];
				default: ;
			endcase
		endfunction

		function bit frame_open();
			return byte_pos != 0 || sync_run != 0;
		endfunction

		// Mode step at the end of every frame; returns 1 on manual -> autopilot.
		function logic update_mode();
			logic entered;
			entered = 1'b0;
			if (mode_chan <= auto_thr) begin
				entered = !autopilot;
				autopilot = 1'b1;
				holdoff = {1'b0, hold_reload};
			end else if (mode_chan < manual_ceil) begin
				if (holdoff[7]) begin
					if (autopilot)
						n_fallbacks++;
					autopilot = 1'b0;
				end else begin
					holdoff = holdoff - 8'd1;
				end
			end
			if (entered)
				n_entries++;
			return entered;
		endfunction

		function logic [31:0] be16_signed(int at);
			return {{16{frame_buf[at][7]}}, frame_buf[at], frame_buf[at+1]};
		endfunction

		function logic [31:0] be16_unsigned(int at);
			return {16'd0, frame_buf[at], frame_buf[at+1]};
		endfunction

		function logic [31:0] le32(int at);
			return {frame_buf[at+3], frame_buf[at+2], frame_buf[at+1], frame_buf[at]};
		endfunction

		function void queue_record(logic [4:0] id, logic [31:0] value, logic [1:0] kind,
				logic [1:0] status, logic entered, logic is_last);
			deframe_rec_t r;
			r.id = id;
			r.value = value;
			r.kind = kind;
			r.status = status;
			r.autopilot = autopilot;
			r.entered = entered;
			r.last = is_last;
			expected_records.push_back(r);
		endfunction

		// Advance the prediction by one accepted byte.
		function void note_byte(logic [7:0] b);
			int len, base;
			logic entered;
			logic [1:0] kind, status;
			if (byte_pos == 0) begin
				if (sync_run < 2) begin
					sync_run = (b == igpd_pkg::SYNC_BYTE) ? sync_run + 2'd1 : 2'd0;
					if (sync_run == 2) begin
						frame_buf[0] = igpd_pkg::SYNC_BYTE;
						frame_buf[1] = igpd_pkg::SYNC_BYTE;
					end
					return;
				end
				sync_run = '0;
				if (b == igpd_pkg::TYPE_SENSOR || b == igpd_pkg::TYPE_FULL) begin
					full_frame = (b == igpd_pkg::TYPE_FULL);
					frame_buf[2] = b;
					csum = {8'd0, b};
					byte_pos = igpd_pkg::FIRST_BODY_INDEX;
					return;
				end
				entered = update_mode();
				n_unknown++;
				queue_record(igpd_pkg::ID_SUMMARY, '0, igpd_pkg::KIND_UNKNOWN,
					igpd_pkg::STATUS_UNKNOWN, entered, 1'b1);
				return;
			end
			len = full_frame ? int'(igpd_pkg::LEN_FULL) : int'(igpd_pkg::LEN_SENSOR);
			frame_buf[byte_pos] = b;
			if (byte_pos <= len - 3)
				csum = csum + b;
			byte_pos = byte_pos + 7'd1;
			if (byte_pos < len)
				return;
			byte_pos = '0;
			kind = full_frame ? igpd_pkg::KIND_FULL : igpd_pkg::KIND_SENSOR;
			if (csum != {frame_buf[len-2], frame_buf[len-1]}) begin
				entered = update_mode();
				n_bad_sum++;
				queue_record(igpd_pkg::ID_SUMMARY, '0, kind, igpd_pkg::STATUS_CHECKSUM,
					entered, 1'b1);
				return;
			end
			base = full_frame ? int'(igpd_pkg::SERVO_BASE_FULL) :
				int'(igpd_pkg::SERVO_BASE_SENSOR);
			mode_chan = {frame_buf[base+CH4_OFFSET], frame_buf[base+CH4_OFFSET+1]};
			status = (full_frame && frame_buf[igpd_pkg::GPS_MARK_ADDR] != igpd_pkg::GPS_MARK) ?
				igpd_pkg::STATUS_NO_GPS : igpd_pkg::STATUS_OK;
			if (status == igpd_pkg::STATUS_NO_GPS)
				n_no_gps++;
			else
				n_good++;
			entered = update_mode();
			for (int i = 0; i < SENSOR_WORDS; i++)
				queue_record(igpd_pkg::ID_FIRST + 5'(i), be16_signed(3 + 2 * i), kind,
					status, entered, 1'b0);
			queue_record(ID_PS, be16_signed(PS_AT), kind, status, entered, 1'b0);
			queue_record(ID_PT, be16_signed(PT_AT), kind, status, entered, 1'b0);
			queue_record(ID_SERVO_STATUS, {24'd0, frame_buf[base]}, kind, status,
				entered, 1'b0);
			for (int i = 0; i < SERVO_CHANS; i++)
				queue_record(ID_CH0 + 5'(i), be16_unsigned(base + 1 + 2 * i), kind,
					status, entered, 1'b0);
			if (full_frame && status == igpd_pkg::STATUS_OK) begin
				for (int i = 0; i < GPS_WORDS; i++)
					queue_record(ID_GPS0 + 5'(i), le32(GPS_AT + 4 * i), kind, status,
						entered, 1'b0);
				queue_record(ID_GPS_TOW, {16'd0, frame_buf[TOW_AT+1], frame_buf[TOW_AT]},
					kind, status, entered, 1'b0);
			end
			queue_record(igpd_pkg::ID_SUMMARY, '0, kind, status, entered, 1'b1);
		endfunction

		function void report_field(string name, logic [4:0] id, logic [31:0] want,
				logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: record id %0d, %s mismatch: expected %0h, actual %0h",
					$time, id, name, want, got);
			end
		endfunction

		// Compare one accepted record with the oldest prediction.
		function void check_record(deframe_rec_t got);
			deframe_rec_t want;
			if (expected_records.size() == 0) begin
				errors++;
				$display("%0t: unexpected record: expected none, actual id %0d value %0h",
					$time, got.id, got.value);
				return;
			end
			want = expected_records.pop_front();
			checked++;
			report_field("field_id", want.id, want.id, got.id);
			report_field("field_value", want.id, want.value, got.value);
			report_field("frame_kind", want.id, want.kind, got.kind);
			report_field("frame_status", want.id, want.status, got.status);
			report_field("autopilot_on", want.id, want.autopilot, got.autopilot);
			report_field("entered_autopilot", want.id, want.entered, got.entered);
			report_field("last", want.id, want.last, got.last);
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// DUT and stimulus signals; every input starts at a known value
	// -----------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [4:0]         field_id;
	logic signed [31:0] field_value;
	logic [1:0]         frame_kind;
	logic [1:0]         frame_status;
	logic               autopilot_on;
	logic               entered_autopilot;
	logic               last;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = igpd_pkg::REG_AUTO_THRESHOLD;
	logic [15:0]        cfg_data = 16'd0;

	deframer_scoreboard sb = new();
	deframe_rec_t       seen_rec;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 n_bytes = 0;

	imu_gps_packet_deframer_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.field_id          (field_id),
		.field_value       (field_value),
		.frame_kind        (frame_kind),
		.frame_status      (frame_status),
		.autopilot_on      (autopilot_on),
		.entered_autopilot (entered_autopilot),
		.last              (last),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// Record sink: check each transfer against the prediction, then pick
	// whether to stall for the next cycle. The values read here are the ones
	// that stood before the edge, since the DUT updates through nonblocking
	// assignments.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_rec.id = field_id;
			seen_rec.value = field_value;
			seen_rec.kind = frame_kind;
			seen_rec.status = frame_status;
			seen_rec.autopilot = autopilot_on;
			seen_rec.entered = entered_autopilot;
			seen_rec.last = last;
			sb.check_record(seen_rec);
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// -----------------------------------------------------------------------
	// Driver tasks
	// -----------------------------------------------------------------------

	// Offer one byte, hold it until the transfer, then note it for prediction.
	// Valid stays high on return so back-to-back bytes need no gap.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b);
		n_bytes++;
	endtask

	// Two sync bytes and a type that opens no frame.
	task automatic send_unknown(input logic [7:0] type_byte);
		send_byte(igpd_pkg::SYNC_BYTE);
		send_byte(igpd_pkg::SYNC_BYTE);
		send_byte(type_byte);
	endtask

	function automatic logic [7:0] random_bad_type();
		logic [7:0] t;
		if ($urandom_range(3) == 0)
			return igpd_pkg::SYNC_BYTE;
		do
			t = 8'($urandom_range(255));
		while (t == igpd_pkg::TYPE_SENSOR || t == igpd_pkg::TYPE_FULL);
		return t;
	endfunction

	// Build a complete frame: body fill, servo channel four, GPS marker and
	// trailer (correct or corrupted), then send it byte by byte.
	task automatic send_frame(input bit full, input logic [15:0] ch4, input bit gps_ok,
			input bit sum_ok, input int fill);
		logic [7:0]  pkt [0:igpd_pkg::FRAME_DEPTH-1];
		logic [7:0]  extreme [0:3];
		logic [7:0]  mark;
		logic [15:0] sum;
		int len, base;
		extreme = '{8'h80, 8'h00, 8'h7F, 8'hFF};
		len = full ? int'(igpd_pkg::LEN_FULL) : int'(igpd_pkg::LEN_SENSOR);
		base = full ? int'(igpd_pkg::SERVO_BASE_FULL) : int'(igpd_pkg::SERVO_BASE_SENSOR);
		pkt[0] = igpd_pkg::SYNC_BYTE;
		pkt[1] = igpd_pkg::SYNC_BYTE;
		pkt[2] = full ? igpd_pkg::TYPE_FULL : igpd_pkg::TYPE_SENSOR;
		for (int i = 3; i < len - 2; i++) begin
			case (fill)
				FILL_EXTREME: pkt[i] = extreme[(i - 3) % 4];
				FILL_ONES:    pkt[i] = 8'hFF;
				FILL_ZEROS:   pkt[i] = 8'h00;
				default:      pkt[i] = 8'($urandom_range(255));
			endcase
		end
		pkt[base+CH4_OFFSET] = ch4[15:8];
		pkt[base+CH4_OFFSET+1] = ch4[7:0];
		if (full) begin
			if (gps_ok) begin
				mark = igpd_pkg::GPS_MARK;
			end else begin
				do
					mark = 8'($urandom_range(255));
				while (mark == igpd_pkg::GPS_MARK);
			end
			pkt[igpd_pkg::GPS_MARK_ADDR] = mark;
		end
		sum = '0;
		for (int i = 2; i <= len - 3; i++)
			sum = sum + pkt[i];
		if (!sum_ok)
			sum = sum ^ 16'($urandom_range(1, 65535));
		pkt[len-2] = sum[15:8];
		pkt[len-1] = sum[7:0];
		for (int i = 0; i < len; i++)
			send_byte(pkt[i]);
	endtask

	// Channel four values around the current mode boundaries.
	function automatic logic [15:0] pick_mode_channel();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return sb.auto_thr;
			2, 3: return sb.auto_thr + 16'd1;
			4, 5: return sb.manual_ceil - 16'd1;
			6: return sb.manual_ceil;
			7: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, value);
	endtask

	// Close any open frame or header, drop valid and wait for every
	// predicted record, then wait out the slack so the DUT is idle for a write.
	task automatic finish_phase();
		while (sb.frame_open())
			send_byte(8'h00);
		in_valid <= 1'b0;
		while (sb.expected_records.size() != 0)
			@(posedge clk);
		repeat (CFG_SLACK_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content; the rest is unknown
	// types, hunting noise and frames cut short.
	task automatic run_random(input int n_seq);
		int made, pick;
		made = 0;
		while (made < n_seq) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				send_frame(1'($urandom_range(1)), pick_mode_channel(),
					$urandom_range(4) != 0, $urandom_range(7) != 0, FILL_RANDOM);
				made++;
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) send_unknown(random_bad_type());
				made++;
			end else if (pick < 93) begin
				// noise only: does not count as an item
				repeat ($urandom_range(1, 6))
					send_byte(($urandom_range(2) == 0) ? igpd_pkg::SYNC_BYTE :
						8'($urandom_range(255)));
			end else begin
				send_byte(igpd_pkg::SYNC_BYTE);
				send_byte(igpd_pkg::SYNC_BYTE);
				send_byte($urandom_range(1) ? igpd_pkg::TYPE_FULL : igpd_pkg::TYPE_SENSOR);
				repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(255)));
				made++;
			end
		end
	endtask

	task automatic run_phase(input logic [15:0] thr, input logic [15:0] ceil,
			input logic [6:0] reload, input int idle_pct, input int stall_pct);
		write_cfg(igpd_pkg::REG_AUTO_THRESHOLD, thr);
		write_cfg(igpd_pkg::REG_MANUAL_CEILING, ceil);
		write_cfg(igpd_pkg::REG_HOLDOFF_RELOAD, {9'd0, reload});
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		run_random(RANDOM_SEQS_PER_PHASE);
		finish_phase();
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset configuration: sender idles lightly,
		// receiver stalls about half the time.
		send_idle_pct = 8;
		recv_stall_pct = 51;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(igpd_pkg::SYNC_BYTE);
		send_byte(8'hAA);
		send_unknown(igpd_pkg::SYNC_BYTE);    // third sync byte taken as type
		send_unknown(8'h00);
		send_frame(1'b0, 16'd0, 1'b1, 1'b1, FILL_EXTREME);    // enter autopilot
		send_frame(1'b1, igpd_pkg::AUTO_THRESHOLD_RST + 16'd1, 1'b1, 1'b1, FILL_ONES);
		send_frame(1'b1, 16'hFFFF, 1'b1, 1'b1, FILL_ZEROS);   // mode unchanged
		send_frame(1'b1, 16'd5000, 1'b0, 1'b1, FILL_EXTREME); // GPS marker missing
		send_frame(1'b0, 16'd0, 1'b1, 1'b0, FILL_RANDOM);     // checksum error
		send_frame(1'b1, 16'd0, 1'b1, 1'b0, FILL_RANDOM);     // checksum error
		send_frame(1'b0, igpd_pkg::AUTO_THRESHOLD_RST, 1'b1, 1'b1, FILL_RANDOM);
		send_frame(1'b0, igpd_pkg::MANUAL_CEILING_RST - 16'd1, 1'b1, 1'b1, FILL_RANDOM);
		send_frame(1'b0, igpd_pkg::MANUAL_CEILING_RST, 1'b1, 1'b1, FILL_RANDOM);
		send_unknown(8'hFF);
		finish_phase();

		// Random part over several register settings, extremes and inverted
		// thresholds among them; idling swaps sides, then stops.
		run_phase(16'd0, 16'hFFFF, 7'd0, 8, 51);
		run_phase(16'hFFFF, 16'd0, 7'd127, 8, 51);
		run_phase(16'd30000, 16'd30001, 7'd1, 51, 8);
		run_phase(16'd100, 16'd50000, 7'd2, 51, 8);
		run_phase(16'd40000, 16'd20000, 7'd3, 0, 0);

		// Hold off so that a stray extra record would still be seen.
		repeat (END_SLACK_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes and %0d records: %0d good frames,",
			n_bytes, sb.checked, sb.n_good);
		$display("  %0d checksum errors, %0d without GPS marker, %0d unknown types,",
			sb.n_bad_sum, sb.n_no_gps, sb.n_unknown);
		$display("  %0d autopilot entries, %0d fall-backs", sb.n_entries, sb.n_fallbacks);
		if (sb.errors == 0 && sb.expected_records.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog well above the slowest legal run.
	initial begin
		repeat (WATCHDOG_CYCLES) @(posedge clk);
		$display("%0t: timeout, %0d records still outstanding", $time,
			sb.expected_records.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
